// ----- hdl/l2bi_pkg.sv -----
// Shared types and constants for the 2D lookup table with bilinear interpolation.
`default_nettype none
package l2bi_pkg;

    // Request codes
    localparam logic [1:0] REQ_COL_BP = 2'd0;
    localparam logic [1:0] REQ_ROW_BP = 2'd1;
    localparam logic [1:0] REQ_GRID   = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    // Result codes
    localparam logic [1:0] RK_WRITE_OK = 2'd0;
    localparam logic [1:0] RK_QUERY    = 2'd1;
    localparam logic [1:0] RK_BAD_ADDR = 2'd2;

    // Configuration register indexes (byte address bit 2)
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    // 1.0 as a Q0.16 weight
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    // Number of quotient bits the divider produces
    localparam logic [4:0] DIV_STEPS = 5'd16;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         write_addr;
        logic signed [31:0] write_data;
        logic signed [31:0] col_point;
        logic signed [31:0] row_point;
    } t_req;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] interp_value;
    } t_result;

    // Classification done by the front end
    typedef struct packed {
        logic is_query;
        logic addr_ok;
    } t_cls;

    typedef struct packed {
        t_cls cls;
        t_req req;
    } t_entry;

    // Queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RD_LAST,
        ST_RD_FIRST,
        ST_CLAMP,
        ST_SCAN,
        ST_DIV_SETUP,
        ST_DIV,
        ST_AXIS_DONE,
        ST_WEIGHT,
        ST_MUL_HI,
        ST_ACC_HI,
        ST_ACC_LO,
        ST_DONE
    } t_back_state;

endpackage
`default_nettype wire

// ----- hdl/l2bi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module l2bi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output      logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/l2bi_front.sv -----
// Front end: accepts transactions, classifies them and queues them for the back end.
`default_nettype none
module l2bi_front #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output      logic           o_busy,
    input  wire l2bi_pkg::t_req i_req,
    output      l2bi_pkg::t_head o_head,
    input  wire logic           i_pop
);
    import l2bi_pkg::*;

    t_entry     r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       push;
    t_cls       cls;

    // Classify the incoming transaction
    always_comb begin
        cls.is_query = (i_req.req_type == REQ_QUERY);
        unique case (i_req.req_type)
            REQ_COL_BP: cls.addr_ok = (int'(i_req.write_addr) < MAX_COLS);
            REQ_ROW_BP: cls.addr_ok = (int'(i_req.write_addr) < MAX_ROWS);
            REQ_GRID:   cls.addr_ok = (int'(i_req.write_addr[3:0]) < MAX_COLS) &&
                                      (int'(i_req.write_addr[7:4]) < MAX_ROWS);
            default:    cls.addr_ok = 1'b1;
        endcase
    end

    assign o_busy = (r_count == 2'd2);
    assign push   = i_start && !o_busy;

    // Two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= '{cls: cls, req: i_req};
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_count <= 2'(r_count + 2'(push) - 2'(i_pop));
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.entry = r_slot[r_rd];

    // A lone push grows the queue by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_count == 2'($past(r_count) + 2'd1)))
        else $error("queue count did not follow push");

    // Never pop an empty queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- hdl/l2bi_back.sv -----
// Back end: carries out writes and queries (search, serial divide, weighted blend).
`default_nettype none
module l2bi_back #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire l2bi_pkg::t_head   i_head,
    output      logic              o_pop,
    input  wire logic [4:0]        i_cols_in_use,
    input  wire logic [4:0]        i_rows_in_use,
    output      logic              o_strobe,
    output      l2bi_pkg::t_result o_result
);
    import l2bi_pkg::*;

    localparam int CAW = $clog2(MAX_COLS);
    localparam int RAW = $clog2(MAX_ROWS);
    localparam int IW  = (CAW > RAW) ? CAW : RAW;

    t_back_state r_state, n_state;
    t_entry             r_entry, n_entry;
    logic               r_axis, n_axis;
    logic signed [31:0] r_c, n_c, r_lo, n_lo, r_hi, n_hi;
    logic [IW-1:0]      r_i, n_i, r_ci, n_ci, r_ri, n_ri;
    logic signed [32:0] r_width, n_width;
    logic [32:0]        r_rem, n_rem;
    logic [16:0]        r_quo, n_quo, r_cu, n_cu, r_ru, n_ru;
    logic [4:0]         r_cnt, n_cnt;
    logic [1:0]         r_k, n_k;
    logic [32:0]        r_w, n_w;
    logic signed [31:0] r_v, n_v;
    logic signed [49:0] r_p, n_p;
    logic signed [65:0] r_acc, n_acc;

    logic [IW-1:0]      col_last, row_last, last, bp_raddr;
    logic [31:0]        col_rd, row_rd, grid_rd;
    logic signed [31:0] bp_rd, point;
    logic signed [32:0] width, num;
    logic [33:0]        rem2;
    logic               rem_ge, scan_more, div_zero, div_sat;
    logic [16:0]        wc, wr;
    logic [IW-1:0]      ci_k, ri_k;
    logic signed [65:0] rounded;
    logic               col_we, row_we, grid_we;
    logic [7:0]         grid_raddr;

    // Breakpoint counts in use, saturated into range
    always_comb begin
        if (i_cols_in_use < 5'd2) col_last = IW'(1);
        else if (int'(i_cols_in_use) > MAX_COLS) col_last = IW'(MAX_COLS - 1);
        else col_last = IW'(int'(i_cols_in_use) - 1);
        if (i_rows_in_use < 5'd2) row_last = IW'(1);
        else if (int'(i_rows_in_use) > MAX_ROWS) row_last = IW'(MAX_ROWS - 1);
        else row_last = IW'(int'(i_rows_in_use) - 1);
    end

    // Axis selection and shared arithmetic
    assign last      = r_axis ? row_last : col_last;
    assign bp_rd     = r_axis ? $signed(row_rd) : $signed(col_rd);
    assign point     = r_axis ? r_entry.req.row_point : r_entry.req.col_point;
    assign scan_more = (r_i < last) && (bp_rd < r_c);
    assign width     = 33'(r_hi) - 33'(r_lo);
    assign num       = 33'(r_c) - 33'(r_lo);
    assign div_zero  = (width <= 33'sd0) || (num <= 33'sd0);
    assign div_sat   = (num >= width);
    assign rem2      = {r_rem, 1'b0};
    assign rem_ge    = (rem2 >= {1'b0, r_width});
    assign wc        = r_k[1] ? r_cu : 17'(FRAC_ONE - r_cu);
    assign wr        = r_k[0] ? r_ru : 17'(FRAC_ONE - r_ru);
    assign ci_k      = IW'(r_ci + IW'(r_k[1]));
    assign ri_k      = IW'(r_ri + IW'(r_k[0]));
    assign rounded   = r_acc + 66'sd2147483648;

    // Storage
    l2bi_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_col_ram (
        .i_clk(i_clk), .i_we(col_we), .i_waddr(r_entry.req.write_addr[CAW-1:0]),
        .i_wdata(r_entry.req.write_data), .i_raddr(bp_raddr[CAW-1:0]), .o_rdata(col_rd)
    );
    l2bi_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_row_ram (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(r_entry.req.write_addr[RAW-1:0]),
        .i_wdata(r_entry.req.write_data), .i_raddr(bp_raddr[RAW-1:0]), .o_rdata(row_rd)
    );
    l2bi_ram #(.WIDTH(32), .DEPTH(256)) u_grid_ram (
        .i_clk(i_clk), .i_we(grid_we), .i_waddr(r_entry.req.write_addr),
        .i_wdata(r_entry.req.write_data), .i_raddr(grid_raddr), .o_rdata(grid_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_head.valid) n_state = i_head.entry.cls.is_query ?
                                                      ST_RD_LAST : ST_WRITE;
            ST_WRITE:     n_state = ST_IDLE;
            ST_RD_LAST:   n_state = ST_RD_FIRST;
            ST_RD_FIRST:  n_state = ST_CLAMP;
            ST_CLAMP:     n_state = ST_SCAN;
            ST_SCAN:      if (!scan_more) n_state = ST_DIV_SETUP;
            ST_DIV_SETUP: n_state = (div_zero || div_sat) ? ST_AXIS_DONE : ST_DIV;
            ST_DIV:       if (r_cnt == 5'd1) n_state = ST_AXIS_DONE;
            ST_AXIS_DONE: n_state = r_axis ? ST_WEIGHT : ST_RD_LAST;
            ST_WEIGHT:    n_state = ST_MUL_HI;
            ST_MUL_HI:    n_state = ST_ACC_HI;
            ST_ACC_HI:    n_state = ST_ACC_LO;
            ST_ACC_LO:    n_state = (r_k == 2'd3) ? ST_DONE : ST_WEIGHT;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Outputs, RAM controls
    always_comb begin
        o_pop      = (r_state == ST_IDLE) && i_head.valid;
        o_strobe   = (r_state == ST_WRITE) || (r_state == ST_DONE);
        col_we     = 1'b0;
        row_we     = 1'b0;
        grid_we    = 1'b0;
        bp_raddr   = '0;
        grid_raddr = {4'(ri_k), 4'(ci_k)};
        o_result.result_kind  = RK_WRITE_OK;
        o_result.interp_value = '0;
        unique case (r_state)
            ST_WRITE: begin
                col_we  = r_entry.cls.addr_ok && (r_entry.req.req_type == REQ_COL_BP);
                row_we  = r_entry.cls.addr_ok && (r_entry.req.req_type == REQ_ROW_BP);
                grid_we = r_entry.cls.addr_ok && (r_entry.req.req_type == REQ_GRID);
                o_result.result_kind = r_entry.cls.addr_ok ? RK_WRITE_OK : RK_BAD_ADDR;
            end
            ST_RD_LAST: bp_raddr = last;
            ST_CLAMP:   bp_raddr = IW'(1);
            ST_SCAN:    bp_raddr = IW'(r_i + IW'(1));
            ST_DONE: begin
                o_result.result_kind  = RK_QUERY;
                o_result.interp_value = rounded[63:32];
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_entry = r_entry; n_axis = r_axis; n_c = r_c; n_lo = r_lo; n_hi = r_hi;
        n_i = r_i; n_ci = r_ci; n_ri = r_ri; n_width = r_width; n_rem = r_rem;
        n_quo = r_quo; n_cu = r_cu; n_ru = r_ru; n_cnt = r_cnt; n_k = r_k;
        n_w = r_w; n_v = r_v; n_p = r_p; n_acc = r_acc;
        unique case (r_state)
            ST_IDLE: begin
                n_entry = i_head.entry;
                n_axis  = 1'b0;
            end
            // clamp to the top breakpoint, then to the bottom one
            ST_RD_FIRST: n_c = (point > bp_rd) ? bp_rd : point;
            ST_CLAMP: begin
                n_c  = (r_c < bp_rd) ? bp_rd : r_c;
                n_lo = bp_rd;
                n_i  = IW'(1);
            end
            ST_SCAN: begin
                if (scan_more) begin
                    n_lo = bp_rd;
                    n_i  = IW'(r_i + IW'(1));
                end else begin
                    n_hi = bp_rd;
                end
            end
            ST_DIV_SETUP: begin
                n_width = width;
                n_rem   = num;
                n_cnt   = DIV_STEPS;
                if (div_zero) n_quo = '0;
                else if (div_sat) n_quo = FRAC_ONE;
                else n_quo = '0;
            end
            // restoring division, one quotient bit a cycle
            ST_DIV: begin
                n_rem = rem_ge ? 33'(rem2 - {1'b0, r_width}) : 33'(rem2);
                n_quo = {r_quo[15:0], rem_ge};
                n_cnt = 5'(r_cnt - 5'd1);
            end
            ST_AXIS_DONE: begin
                if (r_axis) begin
                    n_ru  = r_quo;
                    n_ri  = IW'(r_i - IW'(1));
                    n_acc = '0;
                    n_k   = '0;
                end else begin
                    n_cu   = r_quo;
                    n_ci   = IW'(r_i - IW'(1));
                    n_axis = 1'b1;
                end
            end
            ST_WEIGHT: n_w = 33'(34'(wc) * 34'(wr));
            ST_MUL_HI: begin
                n_v = $signed(grid_rd);
                n_p = $signed(grid_rd) * $signed({1'b0, r_w[32:16]});
            end
            ST_ACC_HI: begin
                n_acc = r_acc + (66'(r_p) <<< 16);
                n_p   = r_v * $signed({1'b0, r_w[15:0]});
            end
            ST_ACC_LO: begin
                n_acc = r_acc + 66'(r_p);
                n_k   = 2'(r_k + 2'd1);
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry; r_axis <= n_axis; r_c <= n_c; r_lo <= n_lo; r_hi <= n_hi;
        r_i <= n_i; r_ci <= n_ci; r_ri <= n_ri; r_width <= n_width; r_rem <= n_rem;
        r_quo <= n_quo; r_cu <= n_cu; r_ru <= n_ru; r_cnt <= n_cnt; r_k <= n_k;
        r_w <= n_w; r_v <= n_v; r_p <= n_p; r_acc <= n_acc;
    end

    // Search never runs past the last breakpoint
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_i <= last))
        else $error("breakpoint scan overran");

    // Divider remainder stays below the divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < 33'(r_width)))
        else $error("divider remainder out of range");

    // Fractions never exceed one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AXIS_DONE) |-> (r_quo <= FRAC_ONE))
        else $error("fraction above one");

endmodule
`default_nettype wire

// ----- hdl/lut2d_bilinear_interp.sv -----
// Top level: APB register bank, front end queue and back end engine.
// The back end handles one transaction at a time, with a two-entry queue ahead of it.
// Reset (synchronous, active low) empties the queue, idles the engine, sets both counts
// to 2; tables undefined until written.
`default_nettype none
module lut2d_bilinear_interp #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire l2bi_pkg::t_req    i_req,
    output      logic              o_strobe,
    output      l2bi_pkg::t_result o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);
    import l2bi_pkg::*;

    logic [4:0] r_cols_in_use, r_rows_in_use;
    logic       cfg_wr;
    t_head      head;
    logic       pop;

    // Register bank
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_in_use <= 5'd2;
            r_rows_in_use <= 5'd2;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_COLS) r_cols_in_use <= pwdata[4:0];
            if (paddr[2] == CFG_ROWS) r_rows_in_use <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == CFG_ROWS) ? 32'(r_rows_in_use) : 32'(r_cols_in_use);

    l2bi_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_req(i_req), .o_head(head), .i_pop(pop)
    );

    l2bi_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .o_pop(pop),
        .i_cols_in_use(r_cols_in_use), .i_rows_in_use(r_rows_in_use),
        .o_strobe(o_strobe), .o_result(o_result)
    );

endmodule
`default_nettype wire

// ----- verif/lut2d_bilinear_interp_checker.sv -----
// Checker for the 2D lookup table: predicts every result and compares it on the fly.
`default_nettype none
module lut2d_bilinear_interp_checker #(
    parameter int MAX_COLS = 16,
    parameter int MAX_ROWS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire l2bi_pkg::t_req    i_req,
    input  wire logic              i_strobe,
    input  wire l2bi_pkg::t_result i_result,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [2:0]        i_paddr,
    input  wire logic [31:0]       i_pwdata,
    input  wire logic              i_pready,
    output      int                o_fail_count,
    output      int                o_pending,
    output      int                o_query_count
);
    import l2bi_pkg::*;

    logic signed [31:0] col_bp [MAX_COLS];
    logic signed [31:0] row_bp [MAX_ROWS];
    logic signed [31:0] grid [MAX_ROWS][MAX_COLS];
    logic [4:0]         cols_reg;
    logic [4:0]         rows_reg;
    t_result            expected_q [$];

    assign o_pending = expected_q.size();

    function automatic int clamp_count(logic [4:0] v, int maxv);
        if (v < 2) return 2;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Clamp, search the interval and form the Q0.16 weight along one axis
    function automatic void find_cell(input logic signed [31:0] bp [], input int n,
                                      input logic signed [31:0] p,
                                      output int seg, output logic [16:0] w);
        logic signed [31:0] c;
        longint             span;
        longint             num;
        longint             q;
        int                 i;
        c = p;
        if (c > bp[n-1]) c = bp[n-1];
        if (c < bp[0]) c = bp[0];
        i = 1;
        while (i < n - 1 && bp[i] < c) i++;
        i--;
        span = longint'(bp[i+1]) - longint'(bp[i]);
        num  = longint'(c) - longint'(bp[i]);
        if (span <= 0 || num <= 0) q = 0;
        else begin
            q = (num <<< 16) / span;
            if (q > 65536) q = 65536;
        end
        seg = i;
        w = q[16:0];
    endfunction

    function automatic logic signed [31:0] blend(logic signed [31:0] cp,
                                                 logic signed [31:0] rp);
        logic signed [31:0] cb [];
        logic signed [31:0] rb [];
        int                 ci;
        int                 ri;
        logic [16:0]        cu;
        logic [16:0]        ru;
        longint             acc;
        longint             a;
        longint             b;
        cb = new[MAX_COLS];
        rb = new[MAX_ROWS];
        foreach (cb[k]) cb[k] = col_bp[k];
        foreach (rb[k]) rb[k] = row_bp[k];
        find_cell(cb, clamp_count(cols_reg, MAX_COLS), cp, ci, cu);
        find_cell(rb, clamp_count(rows_reg, MAX_ROWS), rp, ri, ru);
        a = 65536 - longint'(cu);
        b = 65536 - longint'(ru);
        acc = a * b * longint'(grid[ri][ci]);
        acc += a * longint'(ru) * longint'(grid[ri+1][ci]);
        acc += longint'(cu) * b * longint'(grid[ri][ci+1]);
        acc += longint'(cu) * longint'(ru) * longint'(grid[ri+1][ci+1]);
        acc += 64'sd2147483648;
        return 32'(acc >>> 32);
    endfunction

    function automatic t_result predict(t_req r);
        t_result res;
        res.result_kind  = RK_WRITE_OK;
        res.interp_value = '0;
        case (r.req_type)
            REQ_QUERY: begin
                res.result_kind  = RK_QUERY;
                res.interp_value = blend(r.col_point, r.row_point);
            end
            REQ_COL_BP: begin
                if (r.write_addr < MAX_COLS) col_bp[r.write_addr] = r.write_data;
                else res.result_kind = RK_BAD_ADDR;
            end
            REQ_ROW_BP: begin
                if (r.write_addr < MAX_ROWS) row_bp[r.write_addr] = r.write_data;
                else res.result_kind = RK_BAD_ADDR;
            end
            default: begin
                if (r.write_addr[3:0] < MAX_COLS && r.write_addr[7:4] < MAX_ROWS)
                    grid[r.write_addr[7:4]][r.write_addr[3:0]] = r.write_data;
                else res.result_kind = RK_BAD_ADDR;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            cols_reg <= 5'd2;
            rows_reg <= 5'd2;
            expected_q.delete();
            o_fail_count  <= 0;
            o_query_count <= 0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == CFG_COLS) cols_reg <= i_pwdata[4:0];
                else rows_reg <= i_pwdata[4:0];
            end
            // result check before new prediction: a result never arrives in the accept cycle
            if (i_strobe) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: kind %0d value %0d",
                           i_result.result_kind, i_result.interp_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (i_result.result_kind !== exp_res.result_kind) begin
                        $error("result_kind: expected %0d, actual %0d",
                               exp_res.result_kind, i_result.result_kind);
                        o_fail_count <= o_fail_count + 1;
                    end else if (i_result.interp_value !== exp_res.interp_value) begin
                        $error("interp_value: expected %0d, actual %0d",
                               exp_res.interp_value, i_result.interp_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (exp_res.result_kind == RK_QUERY) o_query_count <= o_query_count + 1;
                end
            end
            if (i_start && !i_busy) expected_q = {expected_q, predict(i_req)};
        end
    end
endmodule
`default_nettype wire

// ----- verif/tb_lut2d_bilinear_interp.sv -----
// Testbench top: stimulus, register phases and verdict for the 2D lookup table.
`default_nettype none
module tb_lut2d_bilinear_interp;
    import l2bi_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_strobe;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          query_count;
    int          idle_cycles;
    int          sent;
    int          idle_pct;
    int          ncols;
    int          nrows;
    logic signed [31:0] cbp [16];
    logic signed [31:0] rbp [16];

    lut2d_bilinear_interp u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_strobe(o_strobe), .o_result(o_result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lut2d_bilinear_interp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_req(i_req),
        .i_strobe(o_strobe), .i_result(o_result), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending), .o_query_count(query_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on cycles with no transaction either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One request; random gap beforehand, held for a clock edge and then while busy stays high.
    // start stays high afterwards so back-to-back requests need no gap.
    task automatic send(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_write(logic [1:0] kind, logic [7:0] addr, logic [31:0] data);
        t_req r;
        r = '{req_type: kind, write_addr: addr, write_data: data,
              col_point: $urandom, row_point: $urandom};
        send(r);
    endtask

    task automatic send_query(logic [31:0] cp, logic [31:0] rp);
        t_req r;
        r = '{req_type: REQ_QUERY, write_addr: $urandom, write_data: $urandom,
              col_point: cp, row_point: rp};
        send(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sorted breakpoints over the whole table; duplicates and huge spans now and then
    task automatic load_breaks();
        logic signed [31:0] v;
        int mode;
        mode = $urandom_range(3);
        v = (mode == 0) ? 32'sh8000_0000 : -$signed(32'($urandom_range(400000)));
        for (int k = 0; k < 16; k++) begin
            cbp[k] = v;
            send_write(REQ_COL_BP, 8'(k), v);
            if (mode == 0) v = v + 32'sh1000_0000 - 1;
            else if ($urandom_range(9) != 0 || mode != 1) v = v + $urandom_range(200000, 1);
        end
        v = (mode == 0) ? 32'sh8000_0000 : -$signed(32'($urandom_range(400000)));
        for (int k = 0; k < 16; k++) begin
            rbp[k] = v;
            send_write(REQ_ROW_BP, 8'(k), v);
            if (mode == 0) v = v + 32'sh1000_0000 - 1;
            else if ($urandom_range(9) != 0 || mode != 2) v = v + $urandom_range(200000, 1);
        end
    endtask

    task automatic load_grid();
        for (int k = 0; k < 256; k++) begin
            send_write(REQ_GRID, 8'(k),
                       (k % 37 == 0) ? {1'($urandom_range(1)), 31'h0} : $urandom);
        end
    endtask

    function automatic logic [31:0] pick_point(bit is_col);
        int n;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        n  = is_col ? ncols : nrows;
        lo = is_col ? cbp[0] : rbp[0];
        hi = is_col ? cbp[n-1] : rbp[n-1];
        case ($urandom_range(5))
            0: return $urandom;
            1: return is_col ? cbp[$urandom_range(n-1)] : rbp[$urandom_range(n-1)];
            default: return lo + 32'(longint'($urandom) % (longint'(hi) - longint'(lo) + 1));
        endcase
    endfunction

    initial begin
        logic [31:0] dir_pts [6];
        start = 1'b0; i_req = '0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0; i_rst_n = 1'b0;
        sent = 0; idle_pct = 0; ncols = 2; nrows = 2;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: table load, bad addresses, extremes and register settings
        load_breaks();
        load_grid();
        send_write(REQ_COL_BP, 8'd16, 32'h7FFF_FFFF);
        send_write(REQ_ROW_BP, 8'hFF, 32'h8000_0000);
        dir_pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                    cbp[1], cbp[0] + 1};
        foreach (dir_pts[k]) send_query(dir_pts[k], dir_pts[5-k]);
        drain();
        reg_write(CFG_COLS, 32'd0);
        reg_write(CFG_ROWS, 32'hFFFF_FFFF);
        ncols = 2; nrows = 16;
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        send_query(cbp[1], rbp[7]);
        drain();

        // Random phases with different counts and idle levels
        for (int ph = 0; ph < 8; ph++) begin
            int cfg_c;
            int cfg_r;
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 82;
                2: idle_pct = 0;
                default: idle_pct = 33;
            endcase
            cfg_c = (ph == 0) ? 16 : (ph == 1) ? 2 : $urandom_range(31);
            cfg_r = (ph == 0) ? 16 : (ph == 1) ? 17 : $urandom_range(31);
            reg_write(CFG_COLS, 32'(cfg_c));
            reg_write(CFG_ROWS, 32'(cfg_r));
            ncols = (cfg_c < 2) ? 2 : (cfg_c > 16) ? 16 : cfg_c;
            nrows = (cfg_r < 2) ? 2 : (cfg_r > 16) ? 16 : cfg_r;
            if (ph == 4) load_breaks();
            for (int k = 0; k < 195; k++) begin
                if ($urandom_range(9) < 8) send_query(pick_point(1), pick_point(0));
                else if ($urandom_range(1))
                    send_write(REQ_GRID, 8'($urandom), $urandom);
                else send_write(2'($urandom_range(1)), 8'($urandom_range(16, 255)), $urandom);
            end
            drain();
        end

        $display("Run covered %0d transactions, %0d of them queries, over several table sizes",
                 sent, query_count);
        $display("and idle levels, with breakpoint reloads and out-of-range writes.");
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
